// ----- rtl/wcg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcg_pkg
// Shared types and constants for the window coefficient generator.
// ----------------------------------------------------------------------------
package wcg_pkg;

	typedef enum logic {
		ALU_MUL,
		ALU_DIV
	} alu_op_t;

	typedef struct packed {
		logic        start;
		alu_op_t     op;
		logic [63:0] a;
		logic [63:0] b;
	} alu_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] result;
	} alu_rsp_t;

	typedef struct packed {
		logic        idle;
		logic        done;
		logic [15:0] coef;
		logic [11:0] index;
	} seq_sts_t;

	// configuration register indexes
	localparam logic CFG_WINDOW_TYPE = 1'b0;
	localparam logic CFG_WINDOW_SIZE = 1'b1;

	// window types
	localparam logic [2:0] WIN_HAMMING = 3'd0;
	localparam logic [2:0] WIN_HANN    = 3'd1;
	localparam logic [2:0] WIN_KAISER  = 3'd2;
	localparam logic [2:0] WIN_RAMP    = 3'd3;
	localparam logic [2:0] WIN_RECT    = 3'd4;
	localparam logic [2:0] WIN_SINC    = 3'd5;
	localparam logic [2:0] WIN_TRI     = 3'd6;

	localparam logic [2:0]  RESET_TYPE = WIN_HAMMING;
	localparam logic [12:0] RESET_SIZE = 13'd1024;

	// shared unit step counts (last step index)
	localparam logic [5:0] MUL_LAST = 6'd31;
	localparam logic [5:0] DIV_LAST = 6'd63;

	localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
	localparam logic [63:0] PI_Q30       = 64'd3373259426;
	localparam logic [63:0] HAM_A_Q30    = 64'd579820585;
	localparam logic [63:0] HAM_B_Q30    = 64'd493921239;
	localparam logic [63:0] HANN_B_Q30   = 64'd536870912;
	localparam logic [63:0] ONE_Q32      = 64'd4294967296;
	localparam logic [63:0] Y2_SCALE     = 64'd1212153856; // 1156 << 20
	localparam logic [31:0] Y2_BOT       = 32'd12121539;   // 11.56 in Q20
	localparam logic [63:0] BESSEL_STOP  = 64'd100000000;
	localparam logic [4:0]  MAX_TERMS    = 5'd25;
	localparam logic [2:0]  SIN_TERMS    = 3'd6;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [15:0] ONE_Q15      = 16'd32768;

	// Taylor divisors (2n)(2n+1)
	function automatic logic [63:0] sin_div(input logic [2:0] n);
		logic [63:0] d;
		case (n)
			3'd1:    d = 64'd6;
			3'd2:    d = 64'd20;
			3'd3:    d = 64'd42;
			3'd4:    d = 64'd72;
			3'd5:    d = 64'd110;
			3'd6:    d = 64'd156;
			default: d = 64'd1;
		endcase
		return d;
	endfunction

endpackage

// ----- rtl/wcg_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcg_alu
// Shared shift-add multiplier (64 x 32, 32 steps) and restoring divider
// (64 / 64, 64 steps) on one set of working registers.
// ----------------------------------------------------------------------------
module wcg_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  wcg_pkg::alu_req_t req,
	output wcg_pkg::alu_rsp_t rsp
);

	logic             busy_q;
	logic             done_q;
	wcg_pkg::alu_op_t op_q;
	logic [5:0]       cnt_q;
	logic [63:0]      hi_q;
	logic [63:0]      lo_q;
	logic [63:0]      b_q;

	logic [64:0] rs;
	logic        ge;
	logic [64:0] rdiff;
	logic [5:0]  last;

	assign rs    = {hi_q, lo_q[63]};
	assign rdiff = rs - {1'b0, b_q};
	assign ge    = rs >= {1'b0, b_q};
	assign last  = (op_q == wcg_pkg::ALU_MUL) ? wcg_pkg::MUL_LAST : wcg_pkg::DIV_LAST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= wcg_pkg::ALU_MUL;
			cnt_q  <= '0;
			hi_q   <= '0;
			lo_q   <= '0;
			b_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= '0;
				hi_q   <= '0;
				lo_q   <= req.a;
				b_q    <= req.b;
			end else if (busy_q) begin
				if (op_q == wcg_pkg::ALU_MUL) begin
					// hi accumulates, lo is the shifted multiplicand
					if (b_q[0]) begin
						hi_q <= hi_q + lo_q;
					end
					lo_q <= {lo_q[62:0], 1'b0};
					b_q  <= {1'b0, b_q[63:1]};
				end else begin
					// hi is the partial remainder, lo shifts dividend out, quotient in
					hi_q <= ge ? rdiff[63:0] : rs[63:0];
					lo_q <= {lo_q[62:0], ge};
				end
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = (op_q == wcg_pkg::ALU_MUL) ? hi_q : lo_q;

endmodule

// ----- rtl/wcg_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcg_seq
// Sequencer: walks each window formula as a series of multiply and divide
// requests to the shared unit, with sine and Bessel series as subroutines.
// ----------------------------------------------------------------------------
module wcg_seq #(
	parameter int N_W = 13
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [2:0]        win_type,
	input  logic [N_W-1:0]    win_size,
	input  logic [11:0]       index,
	input  logic              ack,
	output wcg_pkg::seq_sts_t sts,
	output wcg_pkg::alu_req_t alu_req,
	input  wcg_pkg::alu_rsp_t alu_rsp
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_DISPATCH, ST_WAIT,
		ST_HM_PH, ST_HM_C, ST_HM_V, ST_HM_R,
		ST_SIN_START, ST_SIN_X, ST_SIN_X2, ST_SIN_T1, ST_SIN_T2, ST_SIN_END,
		ST_SC_PH, ST_SC_S, ST_SC_PX1, ST_SC_PX2,
		ST_KS_DEN, ST_KS_NUM, ST_KS_Y1, ST_KS_Y2,
		ST_BS_M, ST_BS_D, ST_BS_C, ST_BS_END,
		ST_SAT, ST_FINISH
	} state_t;

	state_t             state_q, nxt_q, sin_ret_q;
	logic [2:0]         type_q;
	logic [N_W-1:0]     n_q;
	logic [11:0]        k_q;
	logic [15:0]        res_q;
	logic               req_start_q;
	wcg_pkg::alu_op_t   req_op_q;
	logic [63:0]        req_a_q, req_b_q;
	logic [31:0]        ph_q;
	logic [1:0]         quad_q;
	logic [31:0]        x2_q;
	logic [2:0]         nn_q;
	logic signed [63:0] sum_q;
	logic [63:0]        aux_q, den_q, t_q, top_q, sde_q, bsum_q;
	logic [31:0]        y2_q;
	logic [4:0]         j_q;
	logic               bot_pass_q;

	logic [63:0] n64, k64, m64, half64, k2, i64, d64, mn64;
	logic [63:0] res, res_sh30, cabs, amp, den50, jsq, rnd, bnext;

	assign n64    = 64'(n_q);
	assign k64    = 64'(k_q);
	assign m64    = n64 - 64'd1;
	assign half64 = n64 >> 1;
	assign k2     = k64 << 1;
	assign i64    = (k64 >= half64) ? (k64 - half64) : (half64 - k64);
	assign d64    = (k2 >= n64) ? (k2 - n64) : (n64 - k2);
	assign mn64   = (k64 < (n64 - k64)) ? k64 : (n64 - k64);

	assign res      = alu_rsp.result;
	assign res_sh30 = res >> 30;
	assign cabs     = sum_q[63] ? $unsigned(-sum_q) : $unsigned(sum_q);
	assign amp      = (type_q == wcg_pkg::WIN_HAMMING) ? (wcg_pkg::HAM_A_Q30 << 30)
	                                                   : (64'd1 << 59);
	assign den50    = (den_q << 5) + (den_q << 4) + (den_q << 1);
	assign jsq      = 64'({5'd0, j_q} * {5'd0, j_q});
	assign rnd      = (t_q + (64'd1 << 44)) >> 45;
	assign bnext    = bsum_q + res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			nxt_q       <= ST_IDLE;
			sin_ret_q   <= ST_IDLE;
			type_q      <= '0;
			n_q         <= '0;
			k_q         <= '0;
			res_q       <= '0;
			req_start_q <= 1'b0;
			req_op_q    <= wcg_pkg::ALU_MUL;
			req_a_q     <= '0;
			req_b_q     <= '0;
			ph_q        <= '0;
			quad_q      <= '0;
			x2_q        <= '0;
			nn_q        <= '0;
			sum_q       <= '0;
			aux_q       <= '0;
			den_q       <= '0;
			t_q         <= '0;
			top_q       <= '0;
			sde_q       <= '0;
			bsum_q      <= '0;
			y2_q        <= '0;
			j_q         <= '0;
			bot_pass_q  <= 1'b0;
		end else begin
			req_start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						type_q  <= win_type;
						n_q     <= win_size;
						k_q     <= index;
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					if (k64 >= n64) begin
						res_q   <= '0;
						state_q <= ST_FINISH;
					end else begin
						unique case (type_q) inside
							wcg_pkg::WIN_HAMMING, wcg_pkg::WIN_HANN: begin
								req_start_q <= 1'b1;
								req_op_q    <= wcg_pkg::ALU_DIV;
								req_a_q     <= (k64 << 32) + (m64 >> 1);
								req_b_q     <= m64;
								nxt_q       <= ST_HM_PH;
								state_q     <= ST_WAIT;
							end
							wcg_pkg::WIN_KAISER: begin
								if (k64 == 64'd0 || k64 == m64) begin
									res_q   <= '0;
									state_q <= ST_FINISH;
								end else begin
									aux_q       <= i64;
									req_start_q <= 1'b1;
									req_op_q    <= wcg_pkg::ALU_MUL;
									req_a_q     <= m64;
									req_b_q     <= m64;
									nxt_q       <= ST_KS_DEN;
									state_q     <= ST_WAIT;
								end
							end
							wcg_pkg::WIN_RAMP: begin
								req_start_q <= 1'b1;
								req_op_q    <= wcg_pkg::ALU_DIV;
								req_a_q     <= ((n64 - k64) << 15) + half64;
								req_b_q     <= n64;
								nxt_q       <= ST_SAT;
								state_q     <= ST_WAIT;
							end
							wcg_pkg::WIN_RECT: begin
								res_q   <= wcg_pkg::ONE_Q15;
								state_q <= ST_FINISH;
							end
							wcg_pkg::WIN_SINC: begin
								if (d64 == 64'd0) begin
									res_q   <= wcg_pkg::ONE_Q15;
									state_q <= ST_FINISH;
								end else begin
									aux_q       <= d64;
									req_start_q <= 1'b1;
									req_op_q    <= wcg_pkg::ALU_DIV;
									req_a_q     <= d64 << 31;
									req_b_q     <= n64;
									nxt_q       <= ST_SC_PH;
									state_q     <= ST_WAIT;
								end
							end
							wcg_pkg::WIN_TRI: begin
								req_start_q <= 1'b1;
								req_op_q    <= wcg_pkg::ALU_DIV;
								req_a_q     <= (mn64 << 16) + half64;
								req_b_q     <= n64;
								nxt_q       <= ST_SAT;
								state_q     <= ST_WAIT;
							end
							default: begin
								res_q   <= '0;
								state_q <= ST_FINISH;
							end
						endcase
					end
				end
				ST_WAIT: begin
					if (alu_rsp.done) begin
						state_q <= nxt_q;
					end
				end
				// Hamming / Hann
				ST_HM_PH: begin
					ph_q      <= res[31:0] + wcg_pkg::QUARTER_TURN;
					sin_ret_q <= ST_HM_C;
					state_q   <= ST_SIN_START;
				end
				ST_HM_C: begin
					req_start_q <= 1'b1;
					req_op_q    <= wcg_pkg::ALU_MUL;
					req_a_q     <= cabs;
					req_b_q     <= (type_q == wcg_pkg::WIN_HAMMING) ? wcg_pkg::HAM_B_Q30
					                                                : wcg_pkg::HANN_B_Q30;
					nxt_q       <= ST_HM_V;
					state_q     <= ST_WAIT;
				end
				ST_HM_V: begin
					t_q     <= sum_q[63] ? (amp + res) : (amp - res);
					state_q <= ST_HM_R;
				end
				ST_HM_R: begin
					if ($signed(t_q) <= 64'sd0) begin
						res_q <= '0;
					end else if (rnd > 64'(wcg_pkg::ONE_Q15)) begin
						res_q <= wcg_pkg::ONE_Q15;
					end else begin
						res_q <= rnd[15:0];
					end
					state_q <= ST_FINISH;
				end
				// sine subroutine: quadrant fold, then Taylor series to x^13
				ST_SIN_START: begin
					quad_q      <= ph_q[31:30];
					req_start_q <= 1'b1;
					req_op_q    <= wcg_pkg::ALU_MUL;
					req_a_q     <= ph_q[30] ? 64'(31'h4000_0000 - {1'b0, ph_q[29:0]})
					                        : 64'(ph_q[29:0]);
					req_b_q     <= wcg_pkg::HALF_PI_Q30;
					nxt_q       <= ST_SIN_X;
					state_q     <= ST_WAIT;
				end
				ST_SIN_X: begin
					sum_q       <= $signed(res_sh30);
					req_start_q <= 1'b1;
					req_op_q    <= wcg_pkg::ALU_MUL;
					req_a_q     <= res_sh30;
					req_b_q     <= res_sh30;
					nxt_q       <= ST_SIN_X2;
					state_q     <= ST_WAIT;
				end
				ST_SIN_X2: begin
					x2_q        <= res_sh30[31:0];
					nn_q        <= 3'd1;
					req_start_q <= 1'b1;
					req_op_q    <= wcg_pkg::ALU_MUL;
					req_a_q     <= $unsigned(sum_q);
					req_b_q     <= res_sh30;
					nxt_q       <= ST_SIN_T1;
					state_q     <= ST_WAIT;
				end
				ST_SIN_T1: begin
					req_start_q <= 1'b1;
					req_op_q    <= wcg_pkg::ALU_DIV;
					req_a_q     <= res_sh30;
					req_b_q     <= wcg_pkg::sin_div(nn_q);
					nxt_q       <= ST_SIN_T2;
					state_q     <= ST_WAIT;
				end
				ST_SIN_T2: begin
					if (nn_q[0]) begin
						sum_q <= sum_q - $signed(res);
					end else begin
						sum_q <= sum_q + $signed(res);
					end
					if (nn_q == wcg_pkg::SIN_TERMS) begin
						state_q <= ST_SIN_END;
					end else begin
						nn_q        <= nn_q + 3'd1;
						req_start_q <= 1'b1;
						req_op_q    <= wcg_pkg::ALU_MUL;
						req_a_q     <= res;
						req_b_q     <= 64'(x2_q);
						nxt_q       <= ST_SIN_T1;
						state_q     <= ST_WAIT;
					end
				end
				ST_SIN_END: begin
					if (quad_q[1]) begin
						sum_q <= -sum_q;
					end
					state_q <= sin_ret_q;
				end
				// sinc
				ST_SC_PH: begin
					ph_q      <= res[31:0];
					sin_ret_q <= ST_SC_S;
					state_q   <= ST_SIN_START;
				end
				ST_SC_S: begin
					if (sum_q <= 64'sd0) begin
						res_q   <= '0;
						state_q <= ST_FINISH;
					end else begin
						req_start_q <= 1'b1;
						req_op_q    <= wcg_pkg::ALU_MUL;
						req_a_q     <= aux_q;
						req_b_q     <= wcg_pkg::PI_Q30;
						nxt_q       <= ST_SC_PX1;
						state_q     <= ST_WAIT;
					end
				end
				ST_SC_PX1: begin
					req_start_q <= 1'b1;
					req_op_q    <= wcg_pkg::ALU_DIV;
					req_a_q     <= res + half64;
					req_b_q     <= n64;
					nxt_q       <= ST_SC_PX2;
					state_q     <= ST_WAIT;
				end
				ST_SC_PX2: begin
					req_start_q <= 1'b1;
					req_op_q    <= wcg_pkg::ALU_DIV;
					req_a_q     <= ($unsigned(sum_q) << 15) + (res >> 1);
					req_b_q     <= res;
					nxt_q       <= ST_SAT;
					state_q     <= ST_WAIT;
				end
				// Kaiser argument y2 = 11.56 * (den - 4 i^2) / den, Q20
				ST_KS_DEN: begin
					den_q       <= res;
					req_start_q <= 1'b1;
					req_op_q    <= wcg_pkg::ALU_MUL;
					req_a_q     <= aux_q;
					req_b_q     <= aux_q;
					nxt_q       <= ST_KS_NUM;
					state_q     <= ST_WAIT;
				end
				ST_KS_NUM: begin
					req_start_q <= 1'b1;
					req_op_q    <= wcg_pkg::ALU_MUL;
					req_a_q     <= den_q - (res << 2);
					req_b_q     <= wcg_pkg::Y2_SCALE;
					nxt_q       <= ST_KS_Y1;
					state_q     <= ST_WAIT;
				end
				ST_KS_Y1: begin
					req_start_q <= 1'b1;
					req_op_q    <= wcg_pkg::ALU_DIV;
					req_a_q     <= res + den50;
					req_b_q     <= den50 << 1;
					nxt_q       <= ST_KS_Y2;
					state_q     <= ST_WAIT;
				end
				ST_KS_Y2: begin
					y2_q        <= res[31:0];
					bot_pass_q  <= 1'b0;
					sde_q       <= wcg_pkg::ONE_Q32;
					bsum_q      <= wcg_pkg::ONE_Q32;
					j_q         <= 5'd1;
					req_start_q <= 1'b1;
					req_op_q    <= wcg_pkg::ALU_MUL;
					req_a_q     <= wcg_pkg::ONE_Q32;
					req_b_q     <= 64'(res[31:0]);
					nxt_q       <= ST_BS_M;
					state_q     <= ST_WAIT;
				end
				// I0 series: top pass with y2, then bottom pass with 11.56
				ST_BS_M: begin
					req_start_q <= 1'b1;
					req_op_q    <= wcg_pkg::ALU_DIV;
					req_a_q     <= res >> 20;
					req_b_q     <= jsq;
					nxt_q       <= ST_BS_D;
					state_q     <= ST_WAIT;
				end
				ST_BS_D: begin
					sde_q       <= res;
					bsum_q      <= bnext;
					req_start_q <= 1'b1;
					req_op_q    <= wcg_pkg::ALU_DIV;
					req_a_q     <= bnext;
					req_b_q     <= wcg_pkg::BESSEL_STOP;
					nxt_q       <= ST_BS_C;
					state_q     <= ST_WAIT;
				end
				ST_BS_C: begin
					if (sde_q < res || j_q == wcg_pkg::MAX_TERMS) begin
						state_q <= ST_BS_END;
					end else begin
						j_q         <= j_q + 5'd1;
						req_start_q <= 1'b1;
						req_op_q    <= wcg_pkg::ALU_MUL;
						req_a_q     <= sde_q;
						req_b_q     <= 64'(y2_q);
						nxt_q       <= ST_BS_M;
						state_q     <= ST_WAIT;
					end
				end
				ST_BS_END: begin
					if (!bot_pass_q) begin
						top_q       <= bsum_q;
						bot_pass_q  <= 1'b1;
						y2_q        <= wcg_pkg::Y2_BOT;
						sde_q       <= wcg_pkg::ONE_Q32;
						bsum_q      <= wcg_pkg::ONE_Q32;
						j_q         <= 5'd1;
						req_start_q <= 1'b1;
						req_op_q    <= wcg_pkg::ALU_MUL;
						req_a_q     <= wcg_pkg::ONE_Q32;
						req_b_q     <= 64'(wcg_pkg::Y2_BOT);
						nxt_q       <= ST_BS_M;
						state_q     <= ST_WAIT;
					end else begin
						req_start_q <= 1'b1;
						req_op_q    <= wcg_pkg::ALU_DIV;
						req_a_q     <= (top_q << 15) + (bsum_q >> 1);
						req_b_q     <= bsum_q;
						nxt_q       <= ST_SAT;
						state_q     <= ST_WAIT;
					end
				end
				ST_SAT: begin
					res_q   <= (res > 64'(wcg_pkg::ONE_Q15)) ? wcg_pkg::ONE_Q15 : res[15:0];
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (ack) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign alu_req.start = req_start_q;
	assign alu_req.op    = req_op_q;
	assign alu_req.a     = req_a_q;
	assign alu_req.b     = req_b_q;

	assign sts.idle  = (state_q == ST_IDLE);
	assign sts.done  = (state_q == ST_FINISH);
	assign sts.coef  = res_q;
	assign sts.index = k_q;

endmodule

// ----- rtl/window_coefficient_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_coefficient_generator
// Window coefficient (Q1.15) for one sample index of the configured window.
// ----------------------------------------------------------------------------
// One request at a time: the block takes a sample index, works it through a
// sequencer driving one shared shift-add multiplier and restoring divider,
// and holds the result in an output register, taking the next request as
// soon as the sequencer is free. A Kaiser coefficient computes two I0 series
// of at most 25 terms, each term one product and two quotients. Indexes at
// or beyond the window size and the unused type code give 0.
// ----------------------------------------------------------------------------
module window_coefficient_generator #(
	parameter int MAX_SIZE = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  logic [11:0] sample_index,
	output logic        coef_valid,
	input  logic        coef_stall,
	output logic [15:0] coefficient,
	output logic [11:0] index_echo
);

	localparam int N_W = $clog2(MAX_SIZE + 1);

	logic [2:0]        window_type_q;
	logic [12:0]       window_size_q;
	logic              coef_valid_q;
	logic [15:0]       coef_q;
	logic [11:0]       echo_q;
	logic [31:0]       ws32, n_clamp;
	logic [N_W-1:0]    n_eff;
	logic              accept, load;
	wcg_pkg::seq_sts_t sts;
	wcg_pkg::alu_req_t alu_req;
	wcg_pkg::alu_rsp_t alu_rsp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_type_q <= wcg_pkg::RESET_TYPE;
			window_size_q <= wcg_pkg::RESET_SIZE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				wcg_pkg::CFG_WINDOW_TYPE: window_type_q <= cfg_data[2:0];
				wcg_pkg::CFG_WINDOW_SIZE: window_size_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// window size clamped to 2..MAX_SIZE
	assign ws32    = 32'(window_size_q);
	assign n_clamp = (ws32 < 32'd2) ? 32'd2
	               : ((ws32 > 32'(MAX_SIZE)) ? 32'(MAX_SIZE) : ws32);
	assign n_eff   = N_W'(n_clamp);

	assign sample_stall = !sts.idle;
	assign accept       = sample_valid && !sample_stall;
	assign load         = sts.done && (!coef_valid_q || !coef_stall);

	wcg_seq #(
		.N_W(N_W)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.win_type(window_type_q),
		.win_size(n_eff),
		.index   (sample_index),
		.ack     (load),
		.sts     (sts),
		.alu_req (alu_req),
		.alu_rsp (alu_rsp)
	);

	wcg_alu u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (alu_req),
		.rsp   (alu_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_valid_q <= 1'b0;
			coef_q       <= '0;
			echo_q       <= '0;
		end else begin
			if (load) begin
				coef_valid_q <= 1'b1;
				coef_q       <= sts.coef;
				echo_q       <= sts.index;
			end else if (!coef_stall) begin
				coef_valid_q <= 1'b0;
			end
		end
	end

	assign coef_valid  = coef_valid_q;
	assign coefficient = coef_q;
	assign index_echo  = echo_q;

endmodule
